// ===== rtl/swfr_pkg.sv =====
// Package for the sliding window frame receiver.
// Holds the window geometry, field widths, codes and the types shared by
// the slot chain and the top level. Depends on nothing.
package swfr_pkg;

  // Receive window and sequence space. The sequence space is a power of two,
  // so sequence arithmetic wraps naturally in SEQ_W bits.
  localparam int WINDOW    = 8;
  localparam int SEQ_SPACE = 256;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);

  // Field widths of the frame header and of the result.
  localparam int ID_W   = 8;
  localparam int FSEQ_W = 8;
  localparam int TAG_W  = 16;

  // Slot index and delivery count widths.
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  // Result kinds.
  localparam logic KIND_DELIVERY = 1'b0;
  localparam logic KIND_ACK      = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELIVER,
    ST_ACK
  } state_t;

  // Commands from the controller to the slot chain.
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [TAG_W-1:0] wr_tag;
  } chain_ctrl_t;

endpackage

// ===== rtl/sliding_window_frame_receiver_unit.sv =====
// Sliding window frame receiver, selective repeat with cumulative acknowledgement.
// Frame headers arrive on the input channel (in_valid / in_stall); results leave
// on the output channel (out_valid / out_stall), one transfer per result.
// A frame addressed to another receiver is taken and yields nothing.
// A frame for this receiver yields zero to eight in-order deliveries followed by
// one acknowledgement flagged with last. The frame header is taken first, then
// each result is loaded into the output register in turn while the output is
// not stalled. The first result passes through the state register and then the
// output register. The slot chain shifts one place per delivery, and there is a
// single output register. The input is stalled until the acknowledgement of a
// frame has been loaded into the output register. When the receiver stalls, the
// output register holds its result and the chain waits. The receiver address is
// written on the cfg port (cfg_ready is always high) and should only change while
// no frame is being processed. Reset empties the window, clears last_received and
// the receiver address; no sweep is needed.
// Uses swfr_pkg and swfr_chain.
module sliding_window_frame_receiver_unit
  import swfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ID_W-1:0]   source_id,
  input  logic [ID_W-1:0]   dest_id,
  input  logic [FSEQ_W-1:0] frame_seq,
  input  logic [TAG_W-1:0]  payload_tag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [FSEQ_W-1:0] out_seq,
  output logic [TAG_W-1:0]  out_tag,
  output logic [FSEQ_W-1:0] ack_number,
  output logic [ID_W-1:0]   ack_source,
  output logic [ID_W-1:0]   ack_dest,
  output logic              last
);

  state_t            state, state_next;
  logic [ID_W-1:0]   receiver_id;
  logic [SEQ_W-1:0]  last_received;
  logic [CNT_W-1:0]  remaining;
  logic [ID_W-1:0]   src_q;
  logic [ID_W-1:0]   dst_q;
  logic [SEQ_W-1:0]  seq_q;

  logic [SEQ_W-1:0]  seq_mod;
  logic [SEQ_W-1:0]  seq_dist;
  logic [SEQ_W-1:0]  next_seq;
  logic              in_win;
  logic              held;
  logic              take;
  logic              load;
  logic              emit_dlv;
  logic              emit_ack;

  chain_ctrl_t       ctrl;
  logic [WINDOW-1:0] slot_valid;
  logic [TAG_W-1:0]  head_tag;

  swfr_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .valid    (slot_valid),
    .head_tag (head_tag)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign load      = !out_valid || !out_stall;

  assign seq_mod  = SEQ_W'(frame_seq);
  assign seq_dist = seq_mod - last_received;
  assign in_win   = (seq_dist != '0) && (seq_dist <= SEQ_W'(WINDOW));
  assign next_seq = last_received + SEQ_W'(1);

  // Every slot before the new frame must already be held for delivery to go ahead.
  always_comb begin
    held = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      if ((SEQ_W'(i + 1) < seq_dist) && !slot_valid[i]) begin
        held = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    take        = 1'b0;
    emit_dlv    = 1'b0;
    emit_ack    = 1'b0;
    ctrl        = '0;
    ctrl.wr_idx = IDX_W'(seq_dist - SEQ_W'(1));
    ctrl.wr_tag = payload_tag;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (dest_id == receiver_id)) begin
          take = 1'b1;
          if (in_win) begin
            ctrl.wr_en = 1'b1;
            state_next = held ? ST_DELIVER : ST_ACK;
          end else begin
            state_next = ST_ACK;
          end
        end
      end
      ST_DELIVER: begin
        if (load) begin
          emit_dlv   = 1'b1;
          ctrl.shift = 1'b1;
          if (remaining == CNT_W'(1)) begin
            state_next = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (load) begin
          emit_ack   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_id   <= '0;
      last_received <= '0;
      remaining     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        receiver_id <= cfg_data;
      end
      if (take && in_win && held) begin
        remaining <= CNT_W'(seq_dist);
      end else if (emit_dlv) begin
        remaining <= remaining - CNT_W'(1);
      end
      if (emit_dlv) begin
        last_received <= next_seq;
      end
      if (load) begin
        out_valid <= emit_dlv || emit_ack;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      src_q <= source_id;
      dst_q <= dest_id;
      seq_q <= seq_mod;
    end
    if (emit_dlv) begin
      kind       <= KIND_DELIVERY;
      out_seq    <= FSEQ_W'(next_seq);
      out_tag    <= head_tag;
      ack_number <= '0;
      ack_source <= '0;
      ack_dest   <= '0;
      last       <= 1'b0;
    end else if (emit_ack) begin
      kind       <= KIND_ACK;
      out_seq    <= FSEQ_W'(seq_q);
      out_tag    <= '0;
      ack_number <= FSEQ_W'(last_received);
      ack_source <= dst_q;
      ack_dest   <= src_q;
      last       <= 1'b1;
    end
  end

endmodule

// ===== rtl/swfr_cell.sv =====
// One slot cell of the receive window: a valid flag and a payload handle.
// On a shift it takes its upper neighbour's contents. Uses swfr_pkg.
module swfr_cell
  import swfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             wr_en,
  input  logic [TAG_W-1:0] wr_tag,
  input  logic             nb_valid,
  input  logic [TAG_W-1:0] nb_tag,
  output logic             valid,
  output logic [TAG_W-1:0] tag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= nb_valid;
    end else if (wr_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag <= nb_tag;
    end else if (wr_en) begin
      tag <= wr_tag;
    end
  end

endmodule

// ===== rtl/swfr_chain.sv =====
// Chain of window slot cells. Cell i holds the frame whose sequence number
// is last_received + 1 + i; a shift moves every slot one place down.
// Uses swfr_pkg and swfr_cell.
module swfr_chain
  import swfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  chain_ctrl_t       ctrl,
  output logic [WINDOW-1:0] valid,
  output logic [TAG_W-1:0]  head_tag
);

  logic [TAG_W-1:0] tag [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic             nb_valid;
    logic [TAG_W-1:0] nb_tag;

    if (i == WINDOW - 1) begin : g_top
      // The slot entering from beyond the window is always empty.
      assign nb_valid = 1'b0;
      assign nb_tag   = '0;
    end else begin : g_mid
      assign nb_valid = valid[i+1];
      assign nb_tag   = tag[i+1];
    end

    swfr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctrl.shift),
      .wr_en    (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(i))),
      .wr_tag   (ctrl.wr_tag),
      .nb_valid (nb_valid),
      .nb_tag   (nb_tag),
      .valid    (valid[i]),
      .tag      (tag[i])
    );
  end

  assign head_tag = tag[0];

endmodule

// ===== rtl/swfr_checker.sv =====
// Port-level checks for the sliding window frame receiver, and the bind that
// attaches them to the top level. Uses swfr_pkg.
module swfr_checker
  import swfr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic kind,
  input logic last
);

  // After reset no result is shown and a frame can be taken.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result pending or input stalled after reset");

  // Only the acknowledgement closes a frame's results.
  a_last_on_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_ACK)))
    else $error("last flag does not match the result kind");

  // A delivered frame is always followed at once by a further result.
  a_dlv_followed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (kind == KIND_DELIVERY)) |=> out_valid)
    else $error("delivery transfer not followed by another result");

  // No new frame is taken while deliveries of the current one are outstanding.
  a_stall_in_dlv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DELIVERY)) |-> in_stall)
    else $error("input open while a delivery is pending");

endmodule

bind sliding_window_frame_receiver_unit swfr_checker u_swfr_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the sliding window frame receiver.
// A predictor of the receive window runs beside the block and every result transfer
// is compared with it. Depends on swfr_pkg and sliding_window_frame_receiver_unit.
`timescale 1ns / 100ps

module tb;
  import swfr_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  typedef struct packed {
    logic              kind;
    logic [FSEQ_W-1:0] seq;
    logic [TAG_W-1:0]  tag;
    logic [FSEQ_W-1:0] ack_number;
    logic [ID_W-1:0]   ack_source;
    logic [ID_W-1:0]   ack_dest;
    logic              last;
  } frame_result_t;

  typedef enum int {
    NOISE_WRONG_DEST,
    NOISE_STALE,
    NOISE_AHEAD,
    NOISE_ANY
  } noise_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ID_W-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ID_W-1:0]   source_id = '0;
  logic [ID_W-1:0]   dest_id = '0;
  logic [FSEQ_W-1:0] frame_seq = '0;
  logic [TAG_W-1:0]  payload_tag = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              kind;
  logic [FSEQ_W-1:0] out_seq;
  logic [TAG_W-1:0]  out_tag;
  logic [FSEQ_W-1:0] ack_number;
  logic [ID_W-1:0]   ack_source;
  logic [ID_W-1:0]   ack_dest;
  logic              last;

  // Predicted state of the receive window.
  logic [ID_W-1:0]   rcv_addr;
  logic [SEQ_W-1:0]  last_in_order;
  logic              held[WINDOW];
  logic [FSEQ_W-1:0] held_seq[WINDOW];
  logic [TAG_W-1:0]  held_tag[WINDOW];

  frame_result_t pending_results[$];
  frame_result_t expected_head;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int frames_sent    = 0;
  int own_frames     = 0;
  int deliveries_seen = 0;
  int acks_seen      = 0;
  int run_length     = 0;
  int longest_run    = 0;

  sliding_window_frame_receiver_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .source_id  (source_id),
    .dest_id    (dest_id),
    .frame_seq  (frame_seq),
    .payload_tag(payload_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_seq    (out_seq),
    .out_tag    (out_tag),
    .ack_number (ack_number),
    .ack_source (ack_source),
    .ack_dest   (ack_dest),
    .last       (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic frame_result_t make_result(input logic k, input int s, input int tg,
                                                input int an, input int asrc, input int adst,
                                                input logic lst);
    frame_result_t r;
    r.kind       = k;
    r.seq        = FSEQ_W'(s);
    r.tag        = TAG_W'(tg);
    r.ack_number = FSEQ_W'(an);
    r.ack_source = ID_W'(asrc);
    r.ack_dest   = ID_W'(adst);
    r.last       = lst;
    return r;
  endfunction

  // Works out the results of one accepted frame and updates the predicted window.
  function automatic void predict_frame(input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst,
                                        input logic [FSEQ_W-1:0] seq_in,
                                        input logic [TAG_W-1:0] tag);
    int seq;
    int seq_dist;
    int slot;
    int s;
    int k;
    bit complete;
    if (dst != rcv_addr) return;
    seq      = int'(seq_in) % SEQ_SPACE;
    seq_dist = (seq + SEQ_SPACE - int'(last_in_order)) % SEQ_SPACE;
    if (seq_dist >= 1 && seq_dist <= WINDOW) begin
      slot = seq % WINDOW;
      held[slot]     = 1'b1;
      held_seq[slot] = FSEQ_W'(seq);
      held_tag[slot] = tag;
      complete = 1'b1;
      for (k = 1; k <= seq_dist && complete; k++) begin
        s    = (int'(last_in_order) + k) % SEQ_SPACE;
        slot = s % WINDOW;
        if (!held[slot] || int'(held_seq[slot]) != s) complete = 1'b0;
      end
      if (complete) begin
        for (k = 1; k <= seq_dist; k++) begin
          s    = (int'(last_in_order) + k) % SEQ_SPACE;
          slot = s % WINDOW;
          pending_results.push_back(make_result(KIND_DELIVERY, s, int'(held_tag[slot]),
                                                0, 0, 0, 1'b0));
          held[slot] = 1'b0;
        end
        last_in_order = SEQ_W'(seq);
      end
    end
    pending_results.push_back(make_result(KIND_ACK, seq, 0, int'(last_in_order),
                                          int'(dst), int'(src), 1'b1));
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d seq %0d tag %0d",
                 $time, kind, out_seq, out_tag);
        error_count++;
      end else begin
        expected_head = pending_results.pop_front();
        check_field("kind", int'(expected_head.kind), int'(kind));
        check_field("out_seq", int'(expected_head.seq), int'(out_seq));
        check_field("out_tag", int'(expected_head.tag), int'(out_tag));
        check_field("ack_number", int'(expected_head.ack_number), int'(ack_number));
        check_field("ack_source", int'(expected_head.ack_source), int'(ack_source));
        check_field("ack_dest", int'(expected_head.ack_dest), int'(ack_dest));
        check_field("last", int'(expected_head.last), int'(last));
        if (expected_head.kind == KIND_ACK) begin
          acks_seen++;
          if (run_length > longest_run) longest_run = run_length;
          run_length = 0;
        end else begin
          deliveries_seen++;
          run_length++;
        end
      end
    end
  end

  // Presents one frame header and returns at the edge that takes the transfer, leaving
  // in_valid high so that a following frame can go out back to back.
  task automatic send_frame(input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst,
                            input logic [FSEQ_W-1:0] seq, input logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_id   <= src;
    dest_id     <= dst;
    frame_seq   <= seq;
    payload_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    if (dst == rcv_addr) own_frames++;
    predict_frame(src, dst, seq, tag);
  endtask

  task automatic wait_until_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_receiver_id(input logic [ID_W-1:0] addr);
    in_valid <= 1'b0;
    wait_until_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rcv_addr = addr;
  endtask

  // Stale, far-ahead, misaddressed or wholly random frames between the window traffic.
  task automatic send_noise();
    logic [ID_W-1:0]   dst;
    logic [FSEQ_W-1:0] seq;
    dst = rcv_addr;
    seq = last_in_order;
    case (noise_t'($urandom_range(3)))
      NOISE_WRONG_DEST: dst = rcv_addr ^ ID_W'($urandom_range(255, 1));
      NOISE_STALE:      seq = last_in_order - FSEQ_W'($urandom_range(SEQ_SPACE - WINDOW - 1, 0));
      NOISE_AHEAD:      seq = last_in_order + FSEQ_W'($urandom_range(SEQ_SPACE - 1, WINDOW + 1));
      default: begin
        dst = ID_W'($urandom);
        seq = FSEQ_W'($urandom);
      end
    endcase
    send_frame(ID_W'($urandom), dst, seq, TAG_W'($urandom));
  endtask

  // Blocks of up to a window of consecutive frames in shuffled order, so that gaps open
  // and close, with noise mixed in and an occasional repeat of the block's last frame.
  task automatic run_traffic(input int own_count);
    int target;
    int n;
    int j;
    int t;
    int tmp;
    int order[WINDOW];
    logic [SEQ_W-1:0] base;
    target = own_frames + own_count;
    while (own_frames < target) begin
      base = last_in_order;
      n = $urandom_range(WINDOW, 1);
      for (j = 0; j < n; j++) order[j] = j + 1;
      for (j = n - 1; j > 0; j--) begin
        t = $urandom_range(j, 0);
        tmp = order[j];
        order[j] = order[t];
        order[t] = tmp;
      end
      for (j = 0; j < n; j++) begin
        if ($urandom_range(99) < 20) send_noise();
        send_frame(ID_W'($urandom), rcv_addr, FSEQ_W'(base + order[j]), TAG_W'($urandom));
      end
      if ($urandom_range(1) == 1) begin
        send_frame(ID_W'($urandom), rcv_addr, FSEQ_W'(base + n), TAG_W'($urandom));
      end
    end
  endtask

  task automatic test_directed_window();
    int s;
    send_idle_pct  = 12;
    recv_stall_pct = 55;
    write_receiver_id(8'h00);
    send_frame(8'hFF, 8'h00, 8'd1, 16'hFFFF);   // in order, delivered at once
    send_frame(8'h12, 8'hFF, 8'd1, 16'h1234);   // another receiver's frame
    send_frame(8'h00, 8'h00, 8'd1, 16'h0000);   // duplicate of a delivered frame
    send_frame(8'h34, 8'h00, 8'd0, 16'h0101);   // stale
    send_frame(8'h56, 8'h00, 8'hFF, 16'h0202);  // far outside the window
    send_frame(8'h78, 8'h00, 8'd10, 16'h0303);  // one past the window edge
    send_frame(8'h9A, 8'h00, 8'd9, 16'h0404);   // at the window edge, held behind a gap
    send_frame(8'hBC, 8'h00, 8'd3, 16'h0505);   // held behind a gap
    send_frame(8'hBC, 8'h00, 8'd3, 16'h0606);   // repeat of a held frame replaces its tag
    send_frame(8'hDE, 8'h00, 8'd2, 16'h0707);   // closes the gap: 2 goes out, 3 stays held
    for (s = 8; s >= 5; s--) send_frame(8'h01, 8'h00, FSEQ_W'(s), TAG_W'(16'h1000 + s));
    send_frame(8'h02, 8'h00, 8'd4, 16'h1004);   // delivers 3 and 4
    send_frame(8'h03, 8'h00, 8'd9, 16'h2009);   // flushes 5 to 9
    for (s = 11; s <= 17; s++) send_frame(8'h04, 8'h00, FSEQ_W'(s), TAG_W'(16'h3000 + s));
    send_frame(8'h05, 8'h00, 8'd10, 16'h300A);
    send_frame(8'h06, 8'h00, 8'd18, 16'h3012);  // a full window delivered in one go
  endtask

  task automatic test_busy_receiver();
    send_idle_pct  = 12;
    recv_stall_pct = 55;
    write_receiver_id(8'hFF);
    run_traffic(112);
  endtask

  task automatic test_bursty_sender();
    send_idle_pct  = 55;
    recv_stall_pct = 12;
    write_receiver_id(ID_W'($urandom_range(254, 1)));
    run_traffic(112);
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_receiver_id(8'h5A);
    run_traffic(112);
  endtask

  initial begin
    int i;
    rcv_addr      = '0;
    last_in_order = '0;
    for (i = 0; i < WINDOW; i++) held[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_window();
    test_busy_receiver();
    test_bursty_sender();
    test_full_rate();
    in_valid <= 1'b0;
    wait_until_idle();
    $display("Sent %0d frames, %0d addressed here; checked %0d deliveries and %0d acks.",
             frames_sent, own_frames, deliveries_seen, acks_seen);
    $display("Window gaps, repeats, stale and far frames at four addresses; longest run %0d.",
             longest_run);
    if (error_count == 0) begin
      $display("sliding_window_frame_receiver_unit regression: pass");
    end else begin
      $display("sliding_window_frame_receiver_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results still expected.", pending_results.size());
    $display("sliding_window_frame_receiver_unit regression: fail");
    $finish;
  end

endmodule
